/* hdl/aes_cbc_pkg.sv */
// Package for the AES CBC block cipher: payload types, command codes and cipher helper functions.
package aes_cbc_pkg;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
    logic        status;
  } out_item_t;

  localparam logic [1:0] CMD_START    = 2'd0;
  localparam logic [1:0] CMD_ENCRYPT  = 2'd1;
  localparam logic [1:0] CMD_DECRYPT  = 2'd2;
  localparam logic [1:0] CMD_RESERVED = 2'd3;

  localparam logic [2:0] REG_KEY0    = 3'd0;
  localparam logic [2:0] REG_KEY1    = 3'd1;
  localparam logic [2:0] REG_KEY2    = 3'd2;
  localparam logic [2:0] REG_KEY3    = 3'd3;
  localparam logic [2:0] REG_KEYSIZE = 3'd4;
  localparam logic [2:0] REG_IVHI    = 3'd5;
  localparam logic [2:0] REG_IVLO    = 3'd6;
  localparam logic [2:0] REG_CHAIN   = 3'd7;

  localparam logic [7:0] RCON_REDUCE = 8'h1b;

  localparam logic [7:0] SBOX_FWD [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] SBOX_INV [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // Multiply by x in GF(2^8).
  function automatic logic [7:0] xt(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? RCON_REDUCE : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX_FWD[w[31:24]], SBOX_FWD[w[23:16]], SBOX_FWD[w[15:8]], SBOX_FWD[w[7:0]]};
  endfunction

  // Byte k of a state word is bits [127-8k -: 8]; column c holds bytes 4c..4c+3.
  function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    logic [1:0]   src;
    logic [7:0]   v;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = inv ? 2'(c + 4 - r) : 2'(c + r);
        v = s[127 - 8 * (int'(src) * 4 + r) -: 8];
        t[127 - 8 * (c * 4 + r) -: 8] = inv ? SBOX_INV[v] : SBOX_FWD[v];
      end
    end
    return t;
  endfunction

  function automatic logic [31:0] mix_col_fwd(input logic [31:0] a);
    logic [7:0] a0, a1, a2, a3;
    a0 = a[31:24]; a1 = a[23:16]; a2 = a[15:8]; a3 = a[7:0];
    return {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
            a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
            a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
            xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
  endfunction

  // Inverse column mix as a fixed pre-multiply followed by the forward mix.
  function automatic logic [31:0] mix_col_inv(input logic [31:0] a);
    logic [7:0] u, v, a0, a1, a2, a3;
    a0 = a[31:24]; a1 = a[23:16]; a2 = a[15:8]; a3 = a[7:0];
    u = xt(xt(a0 ^ a2));
    v = xt(xt(a1 ^ a3));
    return mix_col_fwd({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
  endfunction

  function automatic logic [127:0] mix(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      t[127 - 32 * c -: 32] = inv ? mix_col_inv(s[127 - 32 * c -: 32])
                                  : mix_col_fwd(s[127 - 32 * c -: 32]);
    end
    return t;
  endfunction

endpackage

/* hdl/aes_cbc_block_cipher_top.sv */
// AES-128/192/256 block cipher with optional CBC chaining, with every round run on a shared round unit.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid / in_ready    | aes_cbc_pkg::in_item_t
//   out     | output    | out_valid / out_ready  | aes_cbc_pkg::out_item_t
//   cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// An encrypt or decrypt result comes after Nr+1 key additions (Nr is 10, 12 or 14):
// each of them fetches its four key words in turn, then runs one round.
// A start transaction runs the key schedule one word per cycle, writing 44, 52 or 60 words.
// Reset is synchronous; the key memory is not cleared and its contents are only used after a start.
// One transaction at a time; a waiting result stalls the input, which reopens in the cycle after the result is taken.
module aes_cbc_block_cipher_top (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  aes_cbc_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output aes_cbc_pkg::out_item_t out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [2:0]             cfg_index,
  input  logic [63:0]            cfg_data
);
  import aes_cbc_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXPAND = 3'd1;
  localparam logic [2:0] ST_FETCH  = 3'd2;
  localparam logic [2:0] ST_ROUND  = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  // Configuration registers.
  logic [63:0] key_word [4];
  logic [1:0]  key_size;
  logic [63:0] iv_high, iv_low;
  logic        chaining_enable;

  // Latched at start.
  logic [3:0]   rounds;
  logic [3:0]   nk;
  logic         chain_on;
  logic         keyed;
  logic [127:0] chain;

  logic [2:0]   state;
  logic [127:0] st;
  logic [127:0] blk_in;
  logic         dec;
  logic [3:0]   rnd;
  logic [1:0]   wsel;
  logic [95:0]  rkey;
  logic [127:0] round_key;

  // Key schedule counters.
  logic [5:0]   widx;
  logic [5:0]   total;
  logic [3:0]   kpos;
  logic [7:0]   rc;
  logic [31:0]  hist [8];

  logic [31:0]  kmem [60];
  logic [5:0]   rd_addr;
  logic [31:0]  rd_data;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) key_word[i] <= '0;
      key_size <= '0;
      iv_high <= '0;
      iv_low <= '0;
      chaining_enable <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KEY0:    key_word[0] <= cfg_data;
        REG_KEY1:    key_word[1] <= cfg_data;
        REG_KEY2:    key_word[2] <= cfg_data;
        REG_KEY3:    key_word[3] <= cfg_data;
        REG_KEYSIZE: key_size <= cfg_data[1:0];
        REG_IVHI:    iv_high <= cfg_data;
        REG_IVLO:    iv_low <= cfg_data;
        REG_CHAIN:   chaining_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Key schedule word, computed from the last nk words kept in a history line.
  logic [31:0] prev_w, kick_w, sched_w, init_w;
  logic [2:0]  init_sel;
  always_comb begin
    prev_w = hist[0];
    kick_w = prev_w;
    if (kpos == 4'd0) begin
      kick_w = sub_word({prev_w[23:0], prev_w[31:24]}) ^ {rc, 24'h0};
    end else if (nk == 4'd8 && kpos == 4'd4) begin
      kick_w = sub_word(prev_w);
    end
    sched_w = hist[3'(nk - 4'd1)] ^ kick_w;
    init_sel = widx[2:0];
    init_w = widx[0] ? key_word[init_sel[2:1]][31:0] : key_word[init_sel[2:1]][63:32];
  end

  logic [31:0] new_w;
  assign new_w = (widx < 6'(nk)) ? init_w : sched_w;

  // Key memory: one write port for the schedule, one registered read port for rounds.
  always_ff @(posedge clk) begin
    if (state == ST_EXPAND) kmem[widx] <= new_w;
    rd_data <= kmem[rd_addr];
  end

  always_comb begin
    rd_addr = 6'({rnd, wsel});
  end

  // The last key word of a round is still on the read port during the round cycle.
  assign round_key = {rkey, rd_data};

  // Round unit: one full round of the chosen direction on the state, or only the key addition on the first.
  logic [127:0] rnd_out;
  logic         first, last;
  assign first = dec ? (rnd == rounds) : (rnd == 4'd0);
  assign last  = dec ? (rnd == 4'd0) : (rnd == rounds);
  always_comb begin
    if (first)         rnd_out = st ^ round_key;
    else if (!dec)     rnd_out = last ? (sub_shift(st, 1'b0) ^ round_key)
                                      : (mix(sub_shift(st, 1'b0), 1'b0) ^ round_key);
    else if (last)     rnd_out = sub_shift(st, 1'b1) ^ round_key;
    else               rnd_out = mix(sub_shift(st, 1'b1) ^ round_key, 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      keyed <= 1'b0;
      chain_on <= 1'b0;
      chain <= '0;
      rounds <= 4'd10;
      nk <= 4'd4;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            blk_in <= {in_data.block_high, in_data.block_low};
            if (in_data.command == CMD_START) begin
              out_data <= '0;
              nk <= (key_size == 2'd0) ? 4'd4 : (key_size == 2'd1) ? 4'd6 : 4'd8;
              rounds <= (key_size == 2'd0) ? 4'd10 : (key_size == 2'd1) ? 4'd12 : 4'd14;
              total <= (key_size == 2'd0) ? 6'd44 : (key_size == 2'd1) ? 6'd52 : 6'd60;
              chain_on <= chaining_enable;
              chain <= {iv_high, iv_low};
              keyed <= 1'b1;
              widx <= '0;
              kpos <= '0;
              rc <= 8'h01;
              state <= ST_EXPAND;
            end else if (!keyed || in_data.command == CMD_RESERVED) begin
              out_data <= {128'h0, !keyed};
              out_valid <= 1'b1;
              state <= ST_DONE;
            end else begin
              out_data <= '0;
              dec <= (in_data.command == CMD_DECRYPT);
              if (in_data.command == CMD_ENCRYPT) begin
                st <= {in_data.block_high, in_data.block_low} ^ (chain_on ? chain : '0);
                rnd <= 4'd0;
              end else begin
                st <= {in_data.block_high, in_data.block_low};
                rnd <= rounds;
              end
              wsel <= 2'd0;
              state <= ST_FETCH;
            end
          end
        end
        ST_EXPAND: begin
          for (int i = 7; i > 0; i--) hist[i] <= hist[i - 1];
          hist[0] <= new_w;
          if (widx >= 6'(nk)) begin
            kpos <= (kpos == nk - 4'd1) ? 4'd0 : kpos + 4'd1;
            if (kpos == 4'd0) rc <= xt(rc);
          end
          widx <= widx + 6'd1;
          if (widx == total - 6'd1) begin
            out_valid <= 1'b1;
            state <= ST_DONE;
          end
        end
        ST_FETCH: begin
          // Collect the four round key words; read data arrives in the cycle after the address.
          wsel <= wsel + 2'd1;
          if (wsel == 2'd3) state <= ST_ROUND;
        end
        ST_ROUND: begin
          st <= rnd_out;
          if (last) begin
            if (!dec) begin
              out_data <= {rnd_out, 1'b0};
              if (chain_on) chain <= rnd_out;
            end else begin
              out_data <= {rnd_out ^ (chain_on ? chain : 128'h0), 1'b0};
              if (chain_on) chain <= blk_in;
            end
            out_valid <= 1'b1;
            state <= ST_DONE;
          end else begin
            rnd <= dec ? rnd - 4'd1 : rnd + 4'd1;
            wsel <= 2'd0;
            state <= ST_FETCH;
          end
        end
        ST_DONE: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Round key assembly from the registered read port: the first three words of each round.
  logic [1:0] wsel_d;
  logic       fetch_d;
  always_ff @(posedge clk) begin
    wsel_d <= wsel;
    fetch_d <= (state == ST_FETCH);
    if (fetch_d && wsel_d != 2'd3) rkey[95 - 32 * int'(wsel_d) -: 32] <= rd_data;
  end

endmodule

/* hdl/aes_cbc_checker.sv */
// Port-level checker for the AES CBC block cipher, bound to the top level.
module aes_cbc_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic cfg_ready
);

  // A result waiting for its consumer holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped while stalled");

  // The block never accepts a new transaction while a result is pending.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input ready with result pending");

  // Accepting an input closes the input side on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("input ready right after accept");

  // After reset there is no result and the configuration port is open.
  a_reset_clean: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && cfg_ready) else $error("bad state after reset");

endmodule

bind aes_cbc_block_cipher_top aes_cbc_checker u_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .cfg_ready(cfg_ready)
);

/* dv/tb.sv */
// Self-checking testbench for the AES block cipher with optional CBC chaining.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import aes_cbc_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic clk;
  logic rst;
  logic in_valid, in_ready;
  in_item_t in_data;
  logic out_valid, out_ready;
  out_item_t out_data;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [63:0] cfg_data;

  aes_cbc_block_cipher_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor copy of the registers and the cipher state.
  logic [63:0] key_reg [4];
  logic [1:0] key_size_reg;
  logic [63:0] iv_hi_reg, iv_lo_reg;
  logic chain_en_reg;
  logic [31:0] sched [60];
  logic [127:0] chain_val;
  logic is_keyed;
  int num_rounds;
  logic chain_on;

  in_item_t pending_blocks [$];
  out_item_t expected_results [$];
  int error_count = 0;
  int idle_cycles = 0;
  bit send_bursts, recv_bursts;
  int recv_hold = 0;
  bit in_fire = 0;
  bit long_stall_req;
  bit long_stall = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic logic [7:0] gf_xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 0;
    for (int k = 0; k < 8; k++) begin
      if (b[0]) p ^= a;
      a = gf_xtime(a);
      b = b >> 1;
    end
    return p;
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] w);
    return {SBOX_FWD[w[31:24]], SBOX_FWD[w[23:16]], SBOX_FWD[w[15:8]], SBOX_FWD[w[7:0]]};
  endfunction

  // Key schedule for the latched key size.
  task automatic expand_schedule();
    int nk;
    logic [31:0] t;
    logic [7:0] rc;
    nk = (key_size_reg == 0) ? 4 : (key_size_reg == 1) ? 6 : 8;
    rc = 8'h01;
    for (int i = 0; i < nk; i++)
      sched[i] = (i % 2 == 0) ? key_reg[i/2][63:32] : key_reg[i/2][31:0];
    for (int i = nk; i < 4 * (nk + 7); i++) begin
      t = sched[i-1];
      if (i % nk == 0) begin
        t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gf_xtime(rc);
      end else if (nk > 6 && i % nk == 4) begin
        t = sbox_word(t);
      end
      sched[i] = sched[i-nk] ^ t;
    end
    num_rounds = nk + 6;
  endtask

  function automatic logic [127:0] add_round(input logic [127:0] s, input int rnd);
    return s ^ {sched[rnd*4], sched[rnd*4+1], sched[rnd*4+2], sched[rnd*4+3]};
  endfunction

  function automatic logic [127:0] byte_sub_shift(input logic [127:0] s, input bit inv);
    logic [127:0] t;
    int src;
    logic [7:0] v;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        src = inv ? (c + 4 - r) % 4 : (c + r) % 4;
        v = s[127 - 8 * (src * 4 + r) -: 8];
        t[127 - 8 * (c * 4 + r) -: 8] = inv ? SBOX_INV[v] : SBOX_FWD[v];
      end
    return t;
  endfunction

  function automatic logic [127:0] column_mix(input logic [127:0] s, input bit inv);
    logic [7:0] coef [4];
    logic [7:0] a [4];
    logic [7:0] o;
    logic [127:0] t;
    if (inv) coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    else coef = '{8'h02, 8'h03, 8'h01, 8'h01};
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) a[k] = s[127 - 8 * (c * 4 + k) -: 8];
      for (int r = 0; r < 4; r++) begin
        o = 0;
        for (int k = 0; k < 4; k++) o ^= gf_mul(a[k], coef[(k + 4 - r) % 4]);
        t[127 - 8 * (c * 4 + r) -: 8] = o;
      end
    end
    return t;
  endfunction

  // Work out the result of one block command and advance the state.
  task automatic predict_block(input in_item_t it);
    out_item_t res;
    logic [127:0] s;
    res = '0;
    if (it.command == CMD_START) begin
      expand_schedule();
      chain_on = chain_en_reg;
      chain_val = {iv_hi_reg, iv_lo_reg};
      is_keyed = 1;
    end else if (!is_keyed) begin
      res.status = 1;
    end else if (it.command == CMD_ENCRYPT) begin
      s = {it.block_high, it.block_low};
      if (chain_on) s ^= chain_val;
      s = add_round(s, 0);
      for (int rnd = 1; rnd < num_rounds; rnd++)
        s = add_round(column_mix(byte_sub_shift(s, 0), 0), rnd);
      s = add_round(byte_sub_shift(s, 0), num_rounds);
      {res.result_high, res.result_low} = s;
      if (chain_on) chain_val = s;
    end else if (it.command == CMD_DECRYPT) begin
      s = add_round({it.block_high, it.block_low}, num_rounds);
      for (int rnd = num_rounds - 1; rnd > 0; rnd--)
        s = column_mix(add_round(byte_sub_shift(s, 1), rnd), 1);
      s = add_round(byte_sub_shift(s, 1), 0);
      if (chain_on) begin
        s ^= chain_val;
        chain_val = {it.block_high, it.block_low};
      end
      {res.result_high, res.result_low} = s;
    end
    expected_results.push_back(res);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Register write over the configuration channel, with the local copy updated.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_KEY0: key_reg[0] = val;
      REG_KEY1: key_reg[1] = val;
      REG_KEY2: key_reg[2] = val;
      REG_KEY3: key_reg[3] = val;
      REG_KEYSIZE: key_size_reg = val[1:0];
      REG_IVHI: iv_hi_reg = val;
      REG_IVLO: iv_lo_reg = val;
      REG_CHAIN: chain_en_reg = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic wait_drained();
    wait (pending_blocks.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (80) @(posedge clk);
  endtask

  function automatic in_item_t block_item(input logic [1:0] cmd);
    in_item_t it;
    it.command = cmd;
    it.block_high = {$urandom, $urandom};
    it.block_low = {$urandom, $urandom};
    return it;
  endfunction

  task automatic configure_all(input logic [1:0] ksize, input bit chain_en, input int pat);
    for (int i = 0; i < 4; i++)
      write_reg(3'(REG_KEY0 + i), pat == 0 ? 64'h0 : pat == 1 ? '1 : {$urandom, $urandom});
    write_reg(REG_KEYSIZE, 64'(ksize));
    write_reg(REG_IVHI, pat == 1 ? '1 : {$urandom, $urandom});
    write_reg(REG_IVLO, pat == 0 ? 64'h0 : {$urandom, $urandom});
    write_reg(REG_CHAIN, 64'(chain_en));
  endtask

  // Input driver: offers queued transactions, with random gaps while send_bursts is set.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else if (in_valid && !in_fire) begin
    end else if (send_bursts && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4) - 1) @(negedge clk);
    end else if (pending_blocks.size() > 0) begin
      in_valid <= 1;
      in_data <= pending_blocks.pop_front();
    end else begin
      in_valid <= 0;
    end
  end

  // Input acceptance: predict the result and tell the driver the transaction went through.
  always @(posedge clk) begin
    in_fire <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      predict_block(in_data);
    end
  end

  // Long receiver stall, counted here while the sender keeps offering.
  initial begin
    wait (long_stall_req);
    @(posedge clk);
    long_stall = 1;
    repeat (300) @(posedge clk);
    long_stall = 0;
  end

  // Output sink: random backpressure while recv_bursts is set, and one long hold.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else if (long_stall) begin
      out_ready <= 0;
    end else if (recv_hold > 0) begin
      out_ready <= 0;
      recv_hold <= recv_hold - 1;
    end else if (recv_bursts && $urandom_range(0, 4) == 0) begin
      out_ready <= 0;
      recv_hold <= $urandom_range(0, 3);
    end else begin
      out_ready <= 1;
    end
  end

  // Monitor: each result transaction against the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", out_data.result_high, 64'h0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.result_high !== want.result_high)
          report_mismatch("result_high", out_data.result_high, want.result_high);
        if (out_data.result_low !== want.result_low)
          report_mismatch("result_low", out_data.result_low, want.result_low);
        if (out_data.status !== want.status)
          report_mismatch("status", 64'(out_data.status), 64'(want.status));
      end
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk) begin
    if (!rst && !(out_valid && out_ready) && !(in_valid && in_ready)) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

  initial begin
    in_item_t it;
    int rnd_cmd;
    rst = 1;
    cfg_valid = 0;
    cfg_index = 0;
    cfg_data = 0;
    in_valid = 0;
    in_data = '0;
    out_ready = 0;
    long_stall_req = 0;
    send_bursts = 1;
    recv_bursts = 1;
    key_reg = '{default: 0};
    key_size_reg = 0;
    iv_hi_reg = 0;
    iv_lo_reg = 0;
    chain_en_reg = 0;
    chain_val = 0;
    is_keyed = 0;
    num_rounds = 10;
    chain_on = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Not keyed: block commands and the reserved command before any start.
    pending_blocks.push_back(block_item(CMD_ENCRYPT));
    pending_blocks.push_back(block_item(CMD_DECRYPT));
    pending_blocks.push_back(block_item(CMD_RESERVED));
    wait_drained();

    // Directed: all-zero key in ECB, all-ones key with chaining, key size three.
    configure_all(2'd0, 0, 0);
    it = '0;
    it.command = CMD_START;
    pending_blocks.push_back(it);
    it.command = CMD_ENCRYPT;
    pending_blocks.push_back(it);
    it.block_high = '1;
    it.block_low = '1;
    pending_blocks.push_back(it);
    it.command = CMD_DECRYPT;
    pending_blocks.push_back(it);
    pending_blocks.push_back(block_item(CMD_RESERVED));
    wait_drained();
    configure_all(2'd2, 1, 1);
    pending_blocks.push_back(block_item(CMD_START));
    for (int i = 0; i < 4; i++) pending_blocks.push_back(block_item(CMD_ENCRYPT));
    for (int i = 0; i < 3; i++) pending_blocks.push_back(block_item(CMD_DECRYPT));
    wait_drained();
    // Registers changed after start only matter at the next start.
    configure_all(2'd3, 0, 2);
    pending_blocks.push_back(block_item(CMD_ENCRYPT));
    pending_blocks.push_back(block_item(CMD_START));
    pending_blocks.push_back(block_item(CMD_ENCRYPT));
    pending_blocks.push_back(block_item(CMD_DECRYPT));
    wait_drained();

    // Random phases across key sizes and chaining modes.
    for (int phase = 0; phase < 16; phase++) begin
      if (phase == 14) begin
        send_bursts = 0;
        recv_bursts = 0;
      end
      configure_all(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                    phase < 2 ? phase : 2);
      pending_blocks.push_back(block_item(CMD_START));
      for (int i = 0; i < 82; i++) begin
        rnd_cmd = $urandom_range(0, 39);
        if (rnd_cmd == 0) it = block_item(CMD_START);
        else if (rnd_cmd == 1) it = block_item(CMD_RESERVED);
        else if (rnd_cmd < 21) it = block_item(CMD_ENCRYPT);
        else it = block_item(CMD_DECRYPT);
        pending_blocks.push_back(it);
      end
      // Long receiver stall while the sender keeps offering.
      if (phase == 5) long_stall_req = 1;
      wait_drained();
    end

    wait_drained();
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
